// ----- hdl/tfse_pkg.sv -----
// Package for the telemetry frame stuffing encoder.
// Holds byte codes, field widths, the controller state type and the
// command/status structs. Depends on nothing.
package tfse_pkg;

    localparam int BYTE_W      = 8;
    localparam int ID_W        = 16;
    localparam int VALUE_W     = 32;
    localparam int FRAME_BYTES = 7;   // header, two id bytes, four value bytes
    localparam int FRAME_W     = FRAME_BYTES * BYTE_W;
    localparam int IDX_W       = $clog2(FRAME_BYTES);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);

    localparam logic [BYTE_W-1:0] HDR_DATA  = 8'h10;
    localparam logic [BYTE_W-1:0] HDR_EMPTY = 8'h00;
    localparam logic [BYTE_W-1:0] ESC_BYTE  = 8'h7D;
    localparam logic [BYTE_W-1:0] FLAG_BYTE = 8'h7E;
    localparam logic [BYTE_W-1:0] ESC_XOR   = 8'h20;

    localparam logic REQ_DATA  = 1'b0;
    localparam logic REQ_EMPTY = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SEND  = 4'b0010,
        S_STUFF = 4'b0100,
        S_CSUM  = 4'b1000
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;        // capture a new request
        logic emit_esc;    // send the escape byte, hold the frame
        logic emit_byte;   // send the current byte as is, sum it, advance
        logic emit_xor;    // send the current byte xor 0x20, sum it, advance
        logic emit_csum;   // send the checksum, clear the sum
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_free;     // output register can take a byte this cycle
        logic need_stuff;   // current byte must be escaped
        logic last_payload; // current byte is the last one before the checksum
    } t_dp_stat;

endpackage

// ----- hdl/tfse_req_if.sv -----
// Request channel of the telemetry frame encoder: valid/ready plus one
// frame request. Depends on tfse_pkg.
interface tfse_req_if;
    logic                         valid;
    logic                         ready;
    logic                         req_type;
    logic [tfse_pkg::ID_W-1:0]    sensor_id;
    logic [tfse_pkg::VALUE_W-1:0] value;

    modport source (output valid, output req_type, output sensor_id, output value,
                    input ready);
    modport sink   (input valid, input req_type, input sensor_id, input value,
                    output ready);
endinterface

// ----- hdl/tfse_tx_if.sv -----
// Byte channel of the telemetry frame encoder: valid/ready plus one wire
// byte and its end-of-frame flag. Depends on tfse_pkg.
interface tfse_tx_if;
    logic                        valid;
    logic                        ready;
    logic [tfse_pkg::BYTE_W-1:0] tx_byte;
    logic                        last_byte;

    modport source (output valid, output tx_byte, output last_byte, input ready);
    modport sink   (input valid, input tx_byte, input last_byte, output ready);
endinterface

// ----- hdl/tfse_ctrl.sv -----
// Controller of the telemetry frame encoder: one-hot state machine that
// sequences header, id, value and checksum bytes. Depends on tfse_pkg.
module tfse_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    output logic               o_req_ready,
    input  tfse_pkg::t_dp_stat i_stat,
    output tfse_pkg::t_dp_cmd  o_cmd
);

    tfse_pkg::t_state r_state;
    tfse_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tfse_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            tfse_pkg::S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = tfse_pkg::S_SEND;
                end
            end
            tfse_pkg::S_SEND: begin
                if (i_stat.out_free) begin
                    if (i_stat.need_stuff) begin
                        o_cmd.emit_esc = 1'b1;
                        n_state        = tfse_pkg::S_STUFF;
                    end else begin
                        o_cmd.emit_byte = 1'b1;
                        if (i_stat.last_payload) begin
                            n_state = tfse_pkg::S_CSUM;
                        end
                    end
                end
            end
            tfse_pkg::S_STUFF: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_xor = 1'b1;
                    n_state = i_stat.last_payload ? tfse_pkg::S_CSUM : tfse_pkg::S_SEND;
                end
            end
            tfse_pkg::S_CSUM: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_csum = 1'b1;
                    n_state         = tfse_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tfse_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/tfse_dp.sv -----
// Datapath of the telemetry frame encoder: frame shift register, byte index,
// end-around-carry sum and the output register. Depends on tfse_pkg, tfse_tx_if.
module tfse_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_req_type,
    input  logic [tfse_pkg::ID_W-1:0]    i_sensor_id,
    input  logic [tfse_pkg::VALUE_W-1:0] i_value,
    input  tfse_pkg::t_dp_cmd            i_cmd,
    output tfse_pkg::t_dp_stat           o_stat,
    tfse_tx_if.source                    o_tx
);

    logic [tfse_pkg::FRAME_W-1:0] r_frame;
    logic [tfse_pkg::IDX_W-1:0]   r_idx;
    logic [tfse_pkg::BYTE_W-1:0]  r_sum;
    logic [tfse_pkg::BYTE_W-1:0]  r_out_byte;
    logic                         r_out_last;
    logic                         r_out_valid;

    logic [tfse_pkg::BYTE_W-1:0]  cur_byte;
    logic [tfse_pkg::BYTE_W:0]    sum_wide;
    logic [tfse_pkg::BYTE_W-1:0]  n_sum;
    logic [tfse_pkg::BYTE_W-1:0]  hdr;
    logic [tfse_pkg::VALUE_W-1:0] val;
    logic                         advance;
    logic                         emit_any;

    assign cur_byte = r_frame[tfse_pkg::BYTE_W-1:0];
    assign advance  = i_cmd.emit_byte | i_cmd.emit_xor;
    assign emit_any = advance | i_cmd.emit_esc | i_cmd.emit_csum;

    // One end-around fold suffices: the folded sum never carries again.
    assign sum_wide = {1'b0, r_sum} + {1'b0, cur_byte};
    assign n_sum    = sum_wide[tfse_pkg::BYTE_W-1:0]
                    + {{(tfse_pkg::BYTE_W-1){1'b0}}, sum_wide[tfse_pkg::BYTE_W]};

    assign hdr = (i_req_type == tfse_pkg::REQ_EMPTY) ? tfse_pkg::HDR_EMPTY
                                                     : tfse_pkg::HDR_DATA;
    assign val = (i_req_type == tfse_pkg::REQ_EMPTY) ? '0 : i_value;

    assign o_stat.out_free     = ~r_out_valid | o_tx.ready;
    assign o_stat.need_stuff   = (cur_byte == tfse_pkg::FLAG_BYTE)
                               | (cur_byte == tfse_pkg::ESC_BYTE);
    assign o_stat.last_payload = (r_idx == tfse_pkg::LAST_IDX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.emit_csum) begin
                r_sum <= '0;
            end else if (advance) begin
                r_sum <= n_sum;
            end
            if (emit_any) begin
                r_out_valid <= 1'b1;
            end else if (o_tx.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_frame <= {val, i_sensor_id, hdr};
            r_idx   <= '0;
        end else if (advance) begin
            r_frame <= {{tfse_pkg::BYTE_W{1'b0}},
                        r_frame[tfse_pkg::FRAME_W-1:tfse_pkg::BYTE_W]};
            r_idx   <= r_idx + 1'b1;
        end
        if (emit_any) begin
            r_out_last <= i_cmd.emit_csum;
            if (i_cmd.emit_esc) begin
                r_out_byte <= tfse_pkg::ESC_BYTE;
            end else if (i_cmd.emit_xor) begin
                r_out_byte <= cur_byte ^ tfse_pkg::ESC_XOR;
            end else if (i_cmd.emit_csum) begin
                r_out_byte <= ~r_sum;
            end else begin
                r_out_byte <= cur_byte;
            end
        end
    end

    assign o_tx.valid     = r_out_valid;
    assign o_tx.tx_byte   = r_out_byte;
    assign o_tx.last_byte = r_out_last;

endmodule

// ----- hdl/telemetry_frame_stuffing_encoder_top.sv -----
// Top level of the telemetry frame stuffing encoder.
// Depends on tfse_pkg, tfse_req_if, tfse_tx_if, tfse_ctrl and tfse_dp.
//
// Usage:
//   i_req carries one request per transfer: req_type (0 = data frame,
//   1 = empty frame), sensor_id and value. o_tx carries the wire bytes of
//   the frame, one byte per transfer, with last_byte set on the checksum.
//   A frame is header, id low/high, four value bytes (LSB first), each
//   escaped as 0x7D, byte^0x20 when it equals 0x7E or 0x7D, then the
//   unescaped checksum (0xFF minus the end-around-carry sum).
//   The request is captured into the frame register, and its first byte
//   then passes through the output register onto o_tx. Throughput: one
//   byte per cycle while o_tx is not stalled; a frame is 8 to 14 bytes, and
//   the byte sequencer handles one frame at a time.
//   i_req.ready is high only while the sequencer is idle. It rises again as
//   the checksum enters the output register, so a new request can be taken
//   while that byte still waits on a stalled receiver.
//   A stall on o_tx holds the output byte and freezes the sequencer.
//   Reset (synchronous, active low) returns the sequencer to idle, clears
//   the running sum and drops o_tx.valid.
module telemetry_frame_stuffing_encoder_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tfse_req_if.sink  i_req,
    tfse_tx_if.source o_tx
);

    tfse_pkg::t_dp_cmd  w_cmd;
    tfse_pkg::t_dp_stat w_stat;
    logic               w_req_ready;

    assign i_req.ready = w_req_ready;

    // Sequence the frame bytes
    tfse_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (w_req_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // Hold the frame, sum it, and drive the byte channel
    tfse_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_type  (i_req.req_type),
        .i_sensor_id (i_req.sensor_id),
        .i_value     (i_req.value),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_tx        (o_tx)
    );

endmodule
